// ===== src/lli_pkg.sv =====
// Shared constants and types for the line intersection block.
`timescale 1ns / 1ps
package lli_pkg;
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MUL_BITS  = 2 * WORD_BITS;
   localparam int QUOT_BITS = WORD_BITS + FRAC_BITS;
   localparam int QDEPTH    = 8;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = QPTR_BITS + 1;
   localparam int FRONT_STAGES = 4;
   localparam int FCNT_BITS = $clog2(FRONT_STAGES + 1);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [MUL_BITS-1:0]  prod_type;

   // Work handed from the front end to the divider.
   typedef struct packed {
      word_type den;
      word_type nx;
      word_type ny;
   } item_type;

   // Occupancy reported for the flow-control decision.
   typedef struct packed {
      logic [FCNT_BITS-1:0] front_cnt;
      logic [QCNT_BITS-1:0] queue_cnt;
   } occ_type;

   // Fixed-point product: take the wrapped word above the fraction bits.
   function automatic word_type fx_take(input prod_type p);
      fx_take = p[FRAC_BITS+WORD_BITS-1:FRAC_BITS];
   endfunction
endpackage

// ===== src/lli_front.sv =====
// Front end: differences, cross products, determinant and numerators.
`timescale 1ns / 1ps
module lli_front import lli_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  word_type             p1x,
   input  word_type             p1y,
   input  word_type             p2x,
   input  word_type             p2y,
   input  word_type             q1x,
   input  word_type             q1y,
   input  word_type             q2x,
   input  word_type             q2y,
   output logic                 out_valid,
   output item_type             out_item,
   output logic [FCNT_BITS-1:0] inflight
);
   logic [FRONT_STAGES-1:0] v_ff;
   word_type dpx1_ff, dpy1_ff, dqx1_ff, dqy1_ff;
   prod_type ma0_ff, ma1_ff, mb0_ff, mb1_ff;
   word_type dpx2_ff, dpy2_ff, dqx2_ff, dqy2_ff, ca2_ff, cb2_ff;
   prod_type md0_ff, md1_ff;
   word_type den3_ff;
   prod_type mx0_ff, mx1_ff, my0_ff, my1_ff;
   item_type item4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[FRONT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      dpx1_ff <= p1x - p2x;
      dpy1_ff <= p1y - p2y;
      dqx1_ff <= q1x - q2x;
      dqy1_ff <= q1y - q2y;
      ma0_ff  <= prod_type'(p1x) * prod_type'(p2y);
      ma1_ff  <= prod_type'(p1y) * prod_type'(p2x);
      mb0_ff  <= prod_type'(q1x) * prod_type'(q2y);
      mb1_ff  <= prod_type'(q1y) * prod_type'(q2x);

      dpx2_ff <= dpx1_ff;
      dpy2_ff <= dpy1_ff;
      dqx2_ff <= dqx1_ff;
      dqy2_ff <= dqy1_ff;
      ca2_ff  <= fx_take(ma0_ff) - fx_take(ma1_ff);
      cb2_ff  <= fx_take(mb0_ff) - fx_take(mb1_ff);
      md0_ff  <= prod_type'(dpx1_ff) * prod_type'(dqy1_ff);
      md1_ff  <= prod_type'(dpy1_ff) * prod_type'(dqx1_ff);

      den3_ff <= fx_take(md0_ff) - fx_take(md1_ff);
      mx0_ff  <= prod_type'(ca2_ff) * prod_type'(dqx2_ff);
      mx1_ff  <= prod_type'(cb2_ff) * prod_type'(dpx2_ff);
      my0_ff  <= prod_type'(ca2_ff) * prod_type'(dqy2_ff);
      my1_ff  <= prod_type'(cb2_ff) * prod_type'(dpy2_ff);

      item4_ff.den <= den3_ff;
      item4_ff.nx  <= fx_take(mx0_ff) - fx_take(mx1_ff);
      item4_ff.ny  <= fx_take(my0_ff) - fx_take(my1_ff);
   end

   assign out_valid = v_ff[FRONT_STAGES-1];
   assign out_item  = item4_ff;
   assign inflight  = FCNT_BITS'($countones(v_ff));
endmodule

// ===== src/lli_queue.sv =====
// Short queue between the front end and the divider.
`timescale 1ns / 1ps
module lli_queue import lli_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  item_type             push_item,
   output logic                 pop,
   output item_type             pop_item,
   output logic [QCNT_BITS-1:0] count
);
   item_type               mem_ff [QDEPTH];
   logic [QPTR_BITS-1:0]   wr_ff, rd_ff;
   logic [QCNT_BITS-1:0]   cnt_ff;

   // The divider never stalls, so any held beat drains at once.
   assign pop      = (cnt_ff != '0);
   assign pop_item = mem_ff[rd_ff];
   assign count    = cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_BITS'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_BITS'(1);
         cnt_ff <= cnt_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end
endmodule

// ===== src/lli_div.sv =====
// Back end: pipelined restoring divider for both coordinates, then saturation.
`timescale 1ns / 1ps
module lli_div import lli_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output word_type out_x,
   output word_type out_y,
   output logic     out_parallel,
   output logic     out_overflow
);
   typedef logic [WORD_BITS-1:0] mag_type;
   typedef logic [QUOT_BITS-1:0] quo_type;

   localparam quo_type LIM_POS = quo_type'({(WORD_BITS-1){1'b1}});

   logic    v_ff   [QUOT_BITS];
   logic    par_ff [QUOT_BITS];
   logic    sx_ff  [QUOT_BITS];
   logic    sy_ff  [QUOT_BITS];
   mag_type d_ff   [QUOT_BITS];
   mag_type rx_ff  [QUOT_BITS];
   mag_type ry_ff  [QUOT_BITS];
   quo_type nx_ff  [QUOT_BITS];
   quo_type ny_ff  [QUOT_BITS];
   quo_type qx_ff  [QUOT_BITS];
   quo_type qy_ff  [QUOT_BITS];

   logic    v_in   [QUOT_BITS];
   logic    par_in [QUOT_BITS];
   logic    sx_in  [QUOT_BITS];
   logic    sy_in  [QUOT_BITS];
   mag_type d_in   [QUOT_BITS];
   mag_type rx_in  [QUOT_BITS];
   mag_type ry_in  [QUOT_BITS];
   quo_type nx_in  [QUOT_BITS];
   quo_type ny_in  [QUOT_BITS];
   quo_type qx_in  [QUOT_BITS];
   quo_type qy_in  [QUOT_BITS];

   mag_type mnx, mny, mden;
   logic    sx0, sy0;

   logic    vo_ff, paro_ff, ovfo_ff;
   word_type xo_ff, yo_ff;
   logic    ovx, ovy;
   word_type resx, resy;

   function automatic mag_type abs_word(input word_type w);
      abs_word = w[WORD_BITS-1] ? mag_type'(-w) : mag_type'(w);
   endfunction

   // One quotient bit: shift in the next dividend bit, subtract when it fits.
   function automatic logic [WORD_BITS:0] div_bit(input mag_type r, input logic b,
                                                  input mag_type d);
      logic [WORD_BITS:0] rs;
      logic ge;
      rs = {r, b};
      ge = (rs >= {1'b0, d});
      div_bit = {ge, ge ? mag_type'(rs - {1'b0, d}) : mag_type'(rs)};
   endfunction

   function automatic word_type sat(input quo_type q, input logic neg,
                                    output logic ovf);
      quo_type lim;
      lim = LIM_POS + quo_type'(neg);
      ovf = (q > lim);
      if (ovf) sat = neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
      else     sat = neg ? -word_type'(q[WORD_BITS-1:0]) : word_type'(q[WORD_BITS-1:0]);
   endfunction

   assign mnx  = abs_word(in_item.nx);
   assign mny  = abs_word(in_item.ny);
   assign mden = abs_word(in_item.den);
   assign sx0  = in_item.nx[WORD_BITS-1] ^ in_item.den[WORD_BITS-1];
   assign sy0  = in_item.ny[WORD_BITS-1] ^ in_item.den[WORD_BITS-1];

   always_comb begin
      logic    pv, pp, psx, psy;
      mag_type pd, prx, pry;
      quo_type pnx, pny, pqx, pqy;
      logic [WORD_BITS:0] sx_r, sy_r;
      for (int k = 0; k < QUOT_BITS; k++) begin
         if (k == 0) begin
            pv  = in_valid;
            pp  = (in_item.den == '0);
            psx = sx0;
            psy = sy0;
            pd  = mden;
            prx = '0;
            pry = '0;
            pnx = {mnx, {FRAC_BITS{1'b0}}};
            pny = {mny, {FRAC_BITS{1'b0}}};
            pqx = '0;
            pqy = '0;
         end else begin
            pv  = v_ff[k-1];
            pp  = par_ff[k-1];
            psx = sx_ff[k-1];
            psy = sy_ff[k-1];
            pd  = d_ff[k-1];
            prx = rx_ff[k-1];
            pry = ry_ff[k-1];
            pnx = nx_ff[k-1];
            pny = ny_ff[k-1];
            pqx = qx_ff[k-1];
            pqy = qy_ff[k-1];
         end
         sx_r      = div_bit(prx, pnx[QUOT_BITS-1], pd);
         sy_r      = div_bit(pry, pny[QUOT_BITS-1], pd);
         v_in[k]   = pv;
         par_in[k] = pp;
         sx_in[k]  = psx;
         sy_in[k]  = psy;
         d_in[k]   = pd;
         rx_in[k]  = sx_r[WORD_BITS-1:0];
         ry_in[k]  = sy_r[WORD_BITS-1:0];
         nx_in[k]  = {pnx[QUOT_BITS-2:0], 1'b0};
         ny_in[k]  = {pny[QUOT_BITS-2:0], 1'b0};
         qx_in[k]  = {pqx[QUOT_BITS-2:0], sx_r[WORD_BITS]};
         qy_in[k]  = {pqy[QUOT_BITS-2:0], sy_r[WORD_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUOT_BITS; k++) v_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < QUOT_BITS; k++) v_ff[k] <= v_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUOT_BITS; k++) begin
         par_ff[k] <= par_in[k];
         sx_ff[k]  <= sx_in[k];
         sy_ff[k]  <= sy_in[k];
         d_ff[k]   <= d_in[k];
         rx_ff[k]  <= rx_in[k];
         ry_ff[k]  <= ry_in[k];
         nx_ff[k]  <= nx_in[k];
         ny_ff[k]  <= ny_in[k];
         qx_ff[k]  <= qx_in[k];
         qy_ff[k]  <= qy_in[k];
      end
   end

   always_comb begin
      resx = sat(qx_ff[QUOT_BITS-1], sx_ff[QUOT_BITS-1], ovx);
      resy = sat(qy_ff[QUOT_BITS-1], sy_ff[QUOT_BITS-1], ovy);
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else       vo_ff <= v_ff[QUOT_BITS-1];
   end

   always_ff @(posedge clock) begin
      paro_ff <= par_ff[QUOT_BITS-1];
      if (par_ff[QUOT_BITS-1]) begin
         xo_ff   <= '0;
         yo_ff   <= '0;
         ovfo_ff <= 1'b0;
      end else begin
         xo_ff   <= resx;
         yo_ff   <= resy;
         ovfo_ff <= ovx | ovy;
      end
   end

   assign out_valid    = vo_ff;
   assign out_x        = xo_ff;
   assign out_y        = yo_ff;
   assign out_parallel = paro_ff;
   assign out_overflow = ovfo_ff;
endmodule

// ===== src/line_line_intersection_fixed.sv =====
// A result strobes once its accepted beat has passed the 4 front stages, the queue,
// the 48 divider stages and one output register.
// Throughput: one beat per cycle; busy rises only if the queue would overrun.
// Reset clears all valid bits and queue pointers; nothing is in flight after it.
// The receiver cannot stall: results leave as soon as the divider finishes.
`timescale 1ns / 1ps
module line_line_intersection_fixed import lli_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  word_type req_line_a_p1_x,
   input  word_type req_line_a_p1_y,
   input  word_type req_line_a_p2_x,
   input  word_type req_line_a_p2_y,
   input  word_type req_line_b_p1_x,
   input  word_type req_line_b_p1_y,
   input  word_type req_line_b_p2_x,
   input  word_type req_line_b_p2_y,
   output logic     rsp_strobe,
   output word_type rsp_cross_x,
   output word_type rsp_cross_y,
   output logic     rsp_parallel,
   output logic     rsp_overflow
);
   logic     accept;
   logic     f_valid, q_pop;
   item_type f_item, q_item;
   occ_type  occ;

   assign accept = start & ~busy;
   assign busy   = ({1'b0, occ.queue_cnt} + (QCNT_BITS+1)'(occ.front_cnt))
                   >= (QCNT_BITS+1)'(QDEPTH);

   lli_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .p1x       (req_line_a_p1_x),
      .p1y       (req_line_a_p1_y),
      .p2x       (req_line_a_p2_x),
      .p2y       (req_line_a_p2_y),
      .q1x       (req_line_b_p1_x),
      .q1y       (req_line_b_p1_y),
      .q2x       (req_line_b_p2_x),
      .q2y       (req_line_b_p2_y),
      .out_valid (f_valid),
      .out_item  (f_item),
      .inflight  (occ.front_cnt)
   );

   lli_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_item (f_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .count     (occ.queue_cnt)
   );

   lli_div u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_pop),
      .in_item      (q_item),
      .out_valid    (rsp_strobe),
      .out_x        (rsp_cross_x),
      .out_y        (rsp_cross_y),
      .out_parallel (rsp_parallel),
      .out_overflow (rsp_overflow)
   );

`ifndef ASSERT_OFF
   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_parallel |-> rsp_cross_x == '0 && rsp_cross_y == '0
                                     && !rsp_overflow)
      else $error("parallel result carries nonzero payload");

   a_no_out_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      occ.queue_cnt <= QCNT_BITS'(QDEPTH))
      else $error("queue count beyond depth");
`endif
endmodule
